// ===== hdl/vms_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// vms_pkg
// Shared types and constants of the VAD margin smoother.
// ---------------------------------------------------------------------------
package vms_pkg;

    localparam int TAG_BITS        = 16;
    localparam int CACHE_DEPTH_DEF = 32;
    localparam int APB_ADDR_BITS   = 4;
    localparam int APB_DATA_BITS   = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_LEAD_FRAMES  = 2'd0;
    localparam logic [1:0] REG_HANG_FRAMES  = 2'd1;
    localparam logic [1:0] REG_ONSET_FRAMES = 2'd2;
    localparam logic [1:0] REG_FORCE_ENABLE = 2'd3;

    // result labels
    localparam logic [1:0] LBL_SIL    = 2'd0;
    localparam logic [1:0] LBL_SPEECH = 2'd1;
    localparam logic [1:0] LBL_END    = 2'd2;

    typedef enum logic [1:0] {
        MODE_SIL    = 2'd0,
        MODE_ONSET  = 2'd1,
        MODE_SPEECH = 2'd2,
        MODE_END    = 2'd3
    } t_mode;

    typedef struct packed {
        logic                kind;
        logic [TAG_BITS-1:0] frame_tag;
        logic                is_speech;
        logic                force_silence;
    } t_in_item;

    typedef struct packed {
        logic [TAG_BITS-1:0] out_tag;
        logic [1:0]          label;
        logic                raw_speech;
        logic                last;
    } t_out_item;

    typedef struct packed {
        logic [3:0] lead_frames;
        logic [7:0] hang_frames;
        logic [4:0] onset_frames;
        logic       force_enable;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic pop_a;
        logic pop_b;
        logic emit;
        logic last;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic a_nz;
        logic a_one;
        logic b_nz;
        logic b_one;
        logic emit;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

// ===== hdl/vms_cfg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// vms_cfg
// APB register file holding the smoother configuration.
// ---------------------------------------------------------------------------
module vms_cfg
    import vms_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [1:0]               i_reg_idx,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign wr_en = psel && penable && pwrite;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (i_reg_idx)
                REG_LEAD_FRAMES:  r_cfg.lead_frames  <= pwdata[3:0];
                REG_HANG_FRAMES:  r_cfg.hang_frames  <= pwdata[7:0];
                REG_ONSET_FRAMES: r_cfg.onset_frames <= pwdata[4:0];
                REG_FORCE_ENABLE: r_cfg.force_enable <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (i_reg_idx)
            REG_LEAD_FRAMES:  prdata = APB_DATA_BITS'(r_cfg.lead_frames);
            REG_HANG_FRAMES:  prdata = APB_DATA_BITS'(r_cfg.hang_frames);
            REG_ONSET_FRAMES: prdata = APB_DATA_BITS'(r_cfg.onset_frames);
            REG_FORCE_ENABLE: prdata = APB_DATA_BITS'(r_cfg.force_enable);
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/vms_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// vms_ctrl
// Sequencer: takes an item, then drives the release pops and direct result.
// ---------------------------------------------------------------------------
module vms_ctrl
    import vms_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PREP  = 5'b00010,
        ST_POP_A = 5'b00100,
        ST_POP_B = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_PREP;
                end
            end
            ST_PREP: begin
                priority if (i_stat.a_nz) begin
                    n_state = ST_POP_A;
                end else if (i_stat.b_nz) begin
                    n_state = ST_POP_B;
                end else if (i_stat.emit) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_POP_A: begin
                if (i_stat.out_free) begin
                    o_cmd.pop_a = 1'b1;
                    if (i_stat.a_one) begin
                        o_cmd.last = !i_stat.b_nz && !i_stat.emit;
                        priority if (i_stat.b_nz) begin
                            n_state = ST_POP_B;
                        end else if (i_stat.emit) begin
                            n_state = ST_EMIT;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_POP_B: begin
                if (i_stat.out_free) begin
                    o_cmd.pop_b = 1'b1;
                    if (i_stat.b_one) begin
                        o_cmd.last = !i_stat.emit;
                        n_state    = i_stat.emit ? ST_EMIT : ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/vms_dp.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// vms_dp
// Datapath: mode and counters, frame cache memory, release plan, result reg.
// ---------------------------------------------------------------------------
module vms_dp
    import vms_pkg::*;
#(
    parameter int CACHE_DEPTH = CACHE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out
);

    localparam int AW         = $clog2(CACHE_DEPTH);
    localparam int CW         = (AW > 4) ? AW : 4;
    localparam int ENTRY_BITS = TAG_BITS + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(CACHE_DEPTH - 1);

    t_mode                 r_mode;
    logic [4:0]            r_onset;
    logic [7:0]            r_tail_cnt;
    logic [AW-1:0]         r_head;
    logic [AW-1:0]         r_tail;
    logic [AW-1:0]         r_fill;
    logic [AW-1:0]         r_cnt_a;
    logic [AW-1:0]         r_cnt_b;
    logic [1:0]            r_lab_a;
    logic [1:0]            r_lab_b;
    logic                  r_emit;
    logic [1:0]            r_emit_lab;
    logic                  r_emit_raw;
    logic [TAG_BITS-1:0]   r_tag;
    logic [ENTRY_BITS-1:0] r_mem [CACHE_DEPTH];
    logic [ENTRY_BITS-1:0] r_rd;
    logic                  r_out_valid;
    t_out_item             r_out;

    // release plan of the item on the input
    logic          p_pre;
    logic          p_push;
    logic          p_rel;
    logic [3:0]    p_keep;
    logic [1:0]    p_rel_lab;
    logic          p_emit;
    logic [1:0]    p_emit_lab;
    logic          p_emit_raw;
    t_mode         p_mode;
    logic [4:0]    p_onset;
    logic [7:0]    p_tail;

    logic [4:0]    onset_inc;
    logic [7:0]    tail_base;
    logic [7:0]    tail_inc;
    logic          ovf;
    logic [AW-1:0] fill2;
    logic [CW-1:0] fill2_x;
    logic [CW-1:0] keep_x;
    logic [AW-1:0] cnt_a;
    logic [AW-1:0] cnt_b;
    logic          pop;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] tail_inc_ptr;
    logic [AW-1:0] rd_addr;

    assign onset_inc = (r_onset == 5'd31) ? r_onset : r_onset + 5'd1;
    assign tail_base = (r_mode == MODE_END) ? r_tail_cnt : 8'd0;
    assign tail_inc  = (tail_base == 8'hFF) ? tail_base : tail_base + 8'd1;

    always_comb begin
        p_pre      = 1'b0;
        p_push     = 1'b0;
        p_rel      = 1'b0;
        p_keep     = 4'd0;
        p_rel_lab  = LBL_SPEECH;
        p_emit     = 1'b0;
        p_emit_lab = LBL_SIL;
        p_emit_raw = 1'b0;
        p_mode     = r_mode;
        p_onset    = r_onset;
        p_tail     = r_tail_cnt;
        if (i_item.kind) begin
            p_rel     = 1'b1;
            p_rel_lab = (r_mode == MODE_SIL || r_mode == MODE_ONSET) ? LBL_SIL : LBL_SPEECH;
        end else begin
            unique case (r_mode)
                MODE_SIL: begin
                    if (!i_item.is_speech) begin
                        p_push    = 1'b1;
                        p_rel     = 1'b1;
                        p_keep    = i_cfg.lead_frames;
                        p_rel_lab = LBL_SIL;
                    end else if (i_cfg.onset_frames != 5'd0) begin
                        p_push  = 1'b1;
                        p_onset = 5'd1;
                        if (i_cfg.onset_frames == 5'd1) begin
                            p_rel  = 1'b1;
                            p_mode = MODE_SPEECH;
                        end else begin
                            p_mode = MODE_ONSET;
                        end
                    end else begin
                        p_mode     = MODE_SPEECH;
                        p_rel      = 1'b1;
                        p_emit     = 1'b1;
                        p_emit_lab = LBL_SPEECH;
                        p_emit_raw = 1'b1;
                    end
                end
                MODE_ONSET: begin
                    p_push = 1'b1;
                    if (!i_item.is_speech) begin
                        p_rel     = 1'b1;
                        p_keep    = i_cfg.lead_frames;
                        p_rel_lab = LBL_SIL;
                        p_mode    = MODE_SIL;
                    end else begin
                        p_onset = onset_inc;
                        if (onset_inc >= i_cfg.onset_frames) begin
                            p_rel  = 1'b1;
                            p_mode = MODE_SPEECH;
                        end
                    end
                end
                MODE_SPEECH, MODE_END: begin
                    if (r_mode == MODE_SPEECH && i_item.is_speech) begin
                        p_rel      = 1'b1;
                        p_emit     = 1'b1;
                        p_emit_lab = LBL_SPEECH;
                        p_emit_raw = 1'b1;
                    end else if (i_item.is_speech) begin
                        // speech again during the right margin
                        p_pre   = 1'b1;
                        p_push  = 1'b1;
                        p_onset = onset_inc;
                        p_mode  = MODE_SPEECH;
                        p_rel   = (onset_inc >= i_cfg.onset_frames);
                    end else begin
                        p_tail = tail_base;
                        p_emit = 1'b1;
                        priority if (i_cfg.force_enable && i_item.force_silence) begin
                            p_pre  = 1'b1;
                            p_mode = MODE_SIL;
                        end else if (i_cfg.hang_frames == 8'd0) begin
                            p_mode = MODE_SIL;
                        end else begin
                            p_pre  = 1'b1;
                            p_tail = tail_inc;
                            if (tail_inc >= i_cfg.hang_frames) begin
                                p_emit_lab = LBL_END;
                                p_mode     = MODE_SIL;
                            end else begin
                                p_emit_lab = LBL_SPEECH;
                                p_mode     = MODE_END;
                            end
                        end
                    end
                end
            endcase
        end
    end

    // cache occupancy arithmetic for the plan
    assign ovf = p_push && !p_pre && (r_fill == LAST_IDX);

    always_comb begin
        priority if (p_pre) begin
            fill2 = AW'(p_push);
        end else if (ovf) begin
            fill2 = r_fill;
        end else begin
            fill2 = r_fill + AW'(p_push);
        end
    end

    assign fill2_x = CW'(fill2);
    assign keep_x  = CW'(p_keep);
    assign cnt_a   = p_pre ? r_fill : AW'(ovf);
    assign cnt_b   = (p_rel && (fill2_x > keep_x)) ? AW'(fill2_x - keep_x) : '0;

    assign pop          = i_cmd.pop_a || i_cmd.pop_b;
    assign head_inc     = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
    assign tail_inc_ptr = (r_tail == LAST_IDX) ? '0 : r_tail + AW'(1);
    assign rd_addr      = pop ? head_inc : r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SIL;
            r_onset     <= '0;
            r_tail_cnt  <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_mode     <= p_mode;
                r_onset    <= p_onset;
                r_tail_cnt <= p_tail;
                r_fill     <= fill2 - cnt_b;
                r_cnt_a    <= cnt_a;
                r_cnt_b    <= cnt_b;
                r_emit     <= p_emit;
                if (p_push) begin
                    r_tail <= tail_inc_ptr;
                end
            end
            if (pop) begin
                r_head <= head_inc;
            end
            if (i_cmd.pop_a) begin
                r_cnt_a <= r_cnt_a - AW'(1);
            end
            if (i_cmd.pop_b) begin
                r_cnt_b <= r_cnt_b - AW'(1);
            end
            if (i_cmd.emit) begin
                r_emit <= 1'b0;
            end
            if (pop || i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_lab_a    <= p_pre ? LBL_SPEECH : LBL_SIL;
            r_lab_b    <= p_rel_lab;
            r_emit_lab <= p_emit_lab;
            r_emit_raw <= p_emit_raw;
            r_tag      <= i_item.frame_tag;
        end
        if (pop) begin
            r_out.out_tag    <= r_rd[ENTRY_BITS-1:1];
            r_out.label      <= i_cmd.pop_a ? r_lab_a : r_lab_b;
            r_out.raw_speech <= r_rd[0];
            r_out.last       <= i_cmd.last;
        end else if (i_cmd.emit) begin
            r_out.out_tag    <= r_tag;
            r_out.label      <= r_emit_lab;
            r_out.raw_speech <= r_emit_raw;
            r_out.last       <= i_cmd.last;
        end
    end

    // frame cache
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && p_push) begin
            r_mem[r_tail] <= {i_item.frame_tag, i_item.is_speech};
        end
        r_rd <= r_mem[rd_addr];
    end

    assign o_stat.a_nz     = (r_cnt_a != '0);
    assign o_stat.a_one    = (r_cnt_a == AW'(1));
    assign o_stat.b_nz     = (r_cnt_b != '0);
    assign o_stat.b_one    = (r_cnt_b == AW'(1));
    assign o_stat.emit     = r_emit;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

// ===== hdl/vad_margin_smoother_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// vad_margin_smoother_top
// Hangover smoothing of per-frame speech/silence decisions.
// ---------------------------------------------------------------------------
// Frames wait in a CACHE_DEPTH-entry cache memory and are released with a
// smoothed label (silence, speech, speech end); an end item flushes the cache.
// One item at a time: an item is accepted, then the cache read turnaround
// (state ST_PREP) passes, then its results follow, at most CACHE_DEPTH of
// them. The single read port of the cache memory sets the rate of one result
// per cycle while the output is not stalled. Each result transfer carries
// last on the final result of its item; an item may produce no result.
// Configure through APB only while idle, with lead_frames + onset_frames
// below CACHE_DEPTH.
// ---------------------------------------------------------------------------
module vad_margin_smoother_top
    import vms_pkg::*;
#(
    parameter int CACHE_DEPTH = CACHE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_item                 i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_item                o_out
);

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    assign pready = 1'b1;

    vms_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .i_reg_idx (paddr[3:2]),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .o_cfg     (cfg)
    );

    vms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    vms_dp #(
        .CACHE_DEPTH (CACHE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_item      (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    a_idle_nothing_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!stat.a_nz && !stat.b_nz && !stat.emit))
        else $error("ready while results are still pending");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.accept, cmd.pop_a, cmd.pop_b, cmd.emit}))
        else $error("more than one datapath command in a cycle");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.pop_a || cmd.pop_b || cmd.emit) |-> stat.out_free)
        else $error("result loaded over an untaken transfer");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.last |=> o_in_ready)
        else $error("item not finished after its last result");

endmodule
`default_nettype wire
